// ===== sv/aocs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aocs_pkg: shared types and constants
// Field widths, register indexes, sensitivity tables and the control and
// status structs passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package aocs_pkg;

	// field widths
	localparam int RAW_W   = 16;
	localparam int OUT_W   = 24;
	localparam int CNT_W   = 13;
	localparam int SUM_W   = 29;
	localparam int OFF_W   = 18;
	localparam int SH_W    = 14;
	localparam int SENS_W  = 15;
	localparam int ONEG_W  = 11;
	localparam int SHAMT_W = 4;
	localparam int PROD_W  = SH_W + SENS_W + 1;
	localparam int MODE_W  = 2;
	localparam int FS_W    = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = CNT_W;
	localparam int AXES    = 3;
	localparam int AXIS_Z  = 2;

	// divider runs one quotient bit per cycle over the full sum width
	localparam int DIV_STEP_W = $clog2(SUM_W);

	localparam int DISCARD_COUNT_DEF = 50;

	// reset values of the registers
	localparam logic [MODE_W-1:0] POWER_MODE_RST    = '0;
	localparam logic [FS_W-1:0]   FULL_SCALE_RST    = '0;
	localparam logic [CNT_W-1:0]  AVERAGE_COUNT_RST = CNT_W'(200);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POWER_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_COUNT = 2'd2;

	// sensitivity in 0.01 mg/LSB, row = power mode, column = full scale;
	// the reserved mode repeats low power
	localparam logic [SENS_W-1:0] SENS_TAB [4][4] = '{
		'{15'd390,  15'd782,  15'd1563, 15'd4690},
		'{15'd98,   15'd195,  15'd390,  15'd1172},
		'{15'd1563, 15'd3126, 15'd6252, 15'd18758},
		'{15'd1563, 15'd3126, 15'd6252, 15'd18758}
	};

	// counts per g, before the mode shift
	localparam logic [ONEG_W-1:0] ONEG_TAB [4][4] = '{
		'{11'd256,  11'd128, 11'd64,  11'd21},
		'{11'd1020, 11'd513, 11'd256, 11'd85},
		'{11'd64,   11'd32,  11'd16,  11'd5},
		'{11'd64,   11'd32,  11'd16,  11'd5}
	};

	localparam logic [SHAMT_W-1:0] SHIFT_TAB [4] = '{4'd6, 4'd4, 4'd8, 4'd8};

	// controller to datapath
	typedef struct packed {
		logic restart;
		logic sign_load;
		logic cnt_inc;
		logic cnt_clear;
		logic acc_add;
		logic div_start;
		logic div_step;
		logic off_load;
		logic conv_load;
		logic out_load;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic disc_done;
		logic acc_done;
	} dp_sts_t;

endpackage

`default_nettype wire

// ===== sv/aocs_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aocs_in_if / aocs_out_if: sample and result channels
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ----------------------------------------------------------------------------
interface aocs_in_if;
	import aocs_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    req_type;
	logic signed [RAW_W-1:0] raw_x;
	logic signed [RAW_W-1:0] raw_y;
	logic signed [RAW_W-1:0] raw_z;

	modport source (output valid, req_type, raw_x, raw_y, raw_z, input ready);
	modport sink   (input valid, req_type, raw_x, raw_y, raw_z, output ready);
endinterface

interface aocs_out_if;
	import aocs_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] accel_x;
	logic signed [OUT_W-1:0] accel_y;
	logic signed [OUT_W-1:0] accel_z;

	modport source (output valid, accel_x, accel_y, accel_z, input ready);
	modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

`default_nettype wire

// ===== sv/accel_offset_calibrate_scale.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// accel_offset_calibrate_scale: accelerometer offset calibration and scaling
// Raw XYZ samples come in on the samples channel; calibrated readings in
// units of 0.01 mg leave on the results channel.
// ----------------------------------------------------------------------------
// Usage:
//  - samples: valid/ready, req_type 1 restarts calibration, 0 carries a
//    raw reading. results: valid/ready, one item per calibrated sample.
//  - The user must write registers power_mode, full_scale, average_count
//    via cfg_we/cfg_idx/cfg_data only while the block is idle; not enforced.
//  - After reset or a restart the first sample fixes the Z sign, the next
//    DISCARD_COUNT samples are dropped and the next average_count are
//    summed; none of these gives a result.
//  - After the last summed sample the input is held off while the bit-serial
//    divider (one quotient bit per cycle over the 29-bit sum) forms the
//    averages and the offsets are loaded.
//  - Calibrated samples: the subtract/shift stage loads on the transfer
//    edge, then the multiply loads the output register once that register
//    is free or emptying, which sets result valid; no new sample is taken
//    before that load, as the controller alternates RUN and MUL steps.
//  - A stalled receiver holds the result register; one more sample is
//    still taken and waits in the shift stage until the register frees.
//  - Reset clears calibration and restores the register defaults; the
//    offsets read as zero until a calibration completes.
// ----------------------------------------------------------------------------
module accel_offset_calibrate_scale
	import aocs_pkg::*;
#(
	parameter int DISCARD_COUNT = DISCARD_COUNT_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	aocs_in_if.sink                    samples,
	aocs_out_if.source                 results
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	aocs_ctrl #(
		.DISCARD_COUNT(DISCARD_COUNT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_req   (samples.req_type),
		.in_ready (samples.ready),
		.out_valid(results.valid),
		.out_ready(results.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	aocs_dp #(
		.DISCARD_COUNT(DISCARD_COUNT)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.raw_x   (samples.raw_x),
		.raw_y   (samples.raw_y),
		.raw_z   (samples.raw_z),
		.cmd     (cmd),
		.sts     (sts),
		.accel_x (results.accel_x),
		.accel_y (results.accel_y),
		.accel_z (results.accel_z)
	);

endmodule

`default_nettype wire

// ===== sv/aocs_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aocs_ctrl: calibration and conversion sequencer
// Walks sign capture, discard, accumulation, offset division and the
// calibrated conversion loop; owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module aocs_ctrl
	import aocs_pkg::*;
#(
	parameter int DISCARD_COUNT = DISCARD_COUNT_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic    in_req,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	output dp_cmd_t      cmd,
	input  wire dp_sts_t sts
);

	typedef enum logic [7:0] {
		ST_SIGN     = 8'b0000_0001,
		ST_DISCARD  = 8'b0000_0010,
		ST_ACCUM    = 8'b0000_0100,
		ST_DIV_LOAD = 8'b0000_1000,
		ST_DIVIDE   = 8'b0001_0000,
		ST_OFFSET   = 8'b0010_0000,
		ST_RUN      = 8'b0100_0000,
		ST_MUL      = 8'b1000_0000
	} state_t;

	localparam logic [DIV_STEP_W-1:0] DIV_LAST = DIV_STEP_W'(SUM_W - 1);

	state_t                state_q, state_nx;
	logic [DIV_STEP_W-1:0] step_q;
	logic                  out_valid_q;
	logic                  xfer;

	assign xfer      = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// next state and datapath commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_SIGN, ST_DISCARD, ST_ACCUM, ST_RUN: begin
				in_ready = 1'b1;
				if (xfer && in_req) begin
					cmd.restart = 1'b1;
					state_nx    = ST_SIGN;
				end else if (xfer) begin
					unique case (state_q)
						ST_SIGN: begin
							cmd.sign_load = 1'b1;
							state_nx = (DISCARD_COUNT == 0) ? ST_ACCUM : ST_DISCARD;
						end
						ST_DISCARD: begin
							cmd.cnt_inc = 1'b1;
							if (sts.disc_done) begin
								cmd.cnt_clear = 1'b1;
								state_nx      = ST_ACCUM;
							end
						end
						ST_ACCUM: begin
							cmd.cnt_inc = 1'b1;
							cmd.acc_add = 1'b1;
							if (sts.acc_done) begin
								state_nx = ST_DIV_LOAD;
							end
						end
						default: begin
							cmd.conv_load = 1'b1;
							state_nx      = ST_MUL;
						end
					endcase
				end
			end
			ST_DIV_LOAD: begin
				cmd.div_start = 1'b1;
				state_nx      = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (step_q == DIV_LAST) begin
					state_nx = ST_OFFSET;
				end
			end
			ST_OFFSET: begin
				cmd.off_load = 1'b1;
				state_nx     = ST_RUN;
			end
			ST_MUL: begin
				// result register must be free or emptying this cycle
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_RUN;
				end
			end
			default: begin
				state_nx = ST_SIGN;
			end
		endcase
	end

	// state, divider step count, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SIGN;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.div_start) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	// the divider finishes after exactly one pass over the sum width
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVIDE && step_q == DIV_LAST) |=> state_q == ST_OFFSET)
		else $error("divider did not hand over to offset load");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while stalled");

	// a taken result with nothing behind it clears valid
	a_valid_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ready && !cmd.out_load) |=> !out_valid_q)
		else $error("result valid held after transfer");

	// no sample is taken while the offsets are being worked out
	a_no_accept_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVIDE || state_q == ST_DIV_LOAD || state_q == ST_OFFSET)
		|-> !cmd.conv_load && !cmd.acc_add)
		else $error("sample taken during offset division");
`endif

endmodule

`default_nettype wire

// ===== sv/aocs_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aocs_dp: calibration and scaling datapath
// Configuration registers, sample counter, per-axis sums, a bit-serial
// restoring divider for the averages, offsets, and the subtract, shift
// and sensitivity multiply of the conversion path.
// ----------------------------------------------------------------------------
module aocs_dp
	import aocs_pkg::*;
#(
	parameter int DISCARD_COUNT = DISCARD_COUNT_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data,
	input  wire logic signed [RAW_W-1:0] raw_x,
	input  wire logic signed [RAW_W-1:0] raw_y,
	input  wire logic signed [RAW_W-1:0] raw_z,
	input  wire dp_cmd_t                 cmd,
	output dp_sts_t                      sts,
	output logic signed [OUT_W-1:0]      accel_x,
	output logic signed [OUT_W-1:0]      accel_y,
	output logic signed [OUT_W-1:0]      accel_z
);

	// configuration
	logic [MODE_W-1:0] pm_q;
	logic [FS_W-1:0]   fs_q;
	logic [CNT_W-1:0]  avg_q;

	// calibration state
	logic [CNT_W-1:0]        cnt_q;
	logic                    z_neg_q;
	logic signed [SUM_W-1:0] sum_q  [AXES];
	logic signed [OFF_W-1:0] off_q  [AXES];
	logic [SUM_W-1:0]        mag_q  [AXES];
	logic [CNT_W-1:0]        rem_q  [AXES];
	logic                    neg_q  [AXES];

	// conversion stages
	logic signed [SH_W-1:0]  sh_s1  [AXES];
	logic signed [OUT_W-1:0] acc_q  [AXES];

	// combinational
	logic signed [RAW_W-1:0]  raw     [AXES];
	logic [CNT_W-1:0]         cnt_nx;
	logic [CNT_W-1:0]         target;
	logic [CNT_W:0]           trial   [AXES];
	logic [CNT_W:0]           trial_d [AXES];
	logic                     trial_ge[AXES];
	logic [OFF_W-1:0]         quo     [AXES];
	logic signed [OFF_W-1:0]  quo_s   [AXES];
	logic signed [OFF_W-1:0]  exp_lane[AXES];
	logic signed [OFF_W:0]    diff    [AXES];
	logic signed [OFF_W:0]    diff_sh [AXES];
	logic signed [PROD_W-1:0] prod    [AXES];
	logic [SHAMT_W-1:0]       shamt;
	logic [SENS_W-1:0]        sens;
	logic [OFF_W-1:0]         exp_mag;

	assign raw[0] = raw_x;
	assign raw[1] = raw_y;
	assign raw[2] = raw_z;

	assign shamt   = SHIFT_TAB[pm_q];
	assign sens    = SENS_TAB[pm_q][fs_q];
	assign exp_mag = OFF_W'(ONEG_TAB[pm_q][fs_q]) << shamt;

	// counter compares; a zero average count acts as one
	assign cnt_nx        = cnt_q + CNT_W'(1);
	assign target        = (avg_q == '0) ? CNT_W'(1) : avg_q;
	assign sts.disc_done = cnt_nx >= CNT_W'(DISCARD_COUNT);
	assign sts.acc_done  = cnt_nx >= target;

	// per-axis divider step, offset and conversion arithmetic
	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			trial[i]    = {rem_q[i], mag_q[i][SUM_W-1]};
			trial_d[i]  = trial[i] - {1'b0, cnt_q};
			trial_ge[i] = trial[i] >= {1'b0, cnt_q};
			quo[i]      = mag_q[i][OFF_W-1:0];
			quo_s[i]    = neg_q[i] ? -$signed(quo[i]) : $signed(quo[i]);
			exp_lane[i] = '0;
			diff[i]     = (OFF_W+1)'(raw[i]) - (OFF_W+1)'(off_q[i]);
			diff_sh[i]  = diff[i] >>> shamt;
			prod[i]     = sh_s1[i] * $signed({1'b0, sens});
		end
		// flat reading: one g on Z with the captured sign
		exp_lane[AXIS_Z] = z_neg_q ? -$signed(exp_mag) : $signed(exp_mag);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_q  <= POWER_MODE_RST;
			fs_q  <= FULL_SCALE_RST;
			avg_q <= AVERAGE_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_POWER_MODE:    pm_q  <= cfg_data[MODE_W-1:0];
				REG_FULL_SCALE:    fs_q  <= cfg_data[FS_W-1:0];
				REG_AVERAGE_COUNT: avg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sample counter and Z sign
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			z_neg_q <= 1'b0;
		end else begin
			if (cmd.restart || cmd.sign_load || cmd.cnt_clear) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_nx;
			end
			if (cmd.restart) begin
				z_neg_q <= 1'b0;
			end else if (cmd.sign_load) begin
				z_neg_q <= raw[AXIS_Z][RAW_W-1];
			end
		end
	end

	// sums, divider and offsets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				sum_q[i] <= '0;
				off_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < AXES; i++) begin
				if (cmd.restart || cmd.sign_load) begin
					sum_q[i] <= '0;
				end else if (cmd.acc_add) begin
					sum_q[i] <= sum_q[i] + SUM_W'(raw[i]);
				end
				if (cmd.off_load) begin
					off_q[i] <= quo_s[i] - exp_lane[i];
				end
			end
		end
	end

	// restoring divide on magnitudes, quotient shifts into mag_q
	always_ff @(posedge clk) begin
		for (int i = 0; i < AXES; i++) begin
			if (cmd.div_start) begin
				neg_q[i] <= sum_q[i][SUM_W-1];
				mag_q[i] <= sum_q[i][SUM_W-1] ? SUM_W'(-sum_q[i]) : SUM_W'(sum_q[i]);
				rem_q[i] <= '0;
			end else if (cmd.div_step) begin
				mag_q[i] <= {mag_q[i][SUM_W-2:0], trial_ge[i]};
				rem_q[i] <= trial_ge[i] ? trial_d[i][CNT_W-1:0] : trial[i][CNT_W-1:0];
			end
		end
	end

	// conversion: subtract and shift, then multiply into the result register
	always_ff @(posedge clk) begin
		for (int i = 0; i < AXES; i++) begin
			if (cmd.conv_load) begin
				sh_s1[i] <= diff_sh[i][SH_W-1:0];
			end
			if (cmd.out_load) begin
				acc_q[i] <= prod[i][OUT_W-1:0];
			end
		end
	end

	assign accel_x = acc_q[0];
	assign accel_y = acc_q[1];
	assign accel_z = acc_q[2];

endmodule

`default_nettype wire
